@@ rtl/gcd_lcm_unit_macros.svh @@
// ---------------------------------------------------------------------------
// gcd_lcm_unit_macros.svh
// Assertion macros for the gcd/lcm unit, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define GLU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcd_lcm_unit: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define GLU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcd_lcm_unit: next-cycle check failed");

`else

`define GLU_ASSERT_SAME(label, ante, cons)
`define GLU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/glu_pkg.sv @@
// ---------------------------------------------------------------------------
// glu_pkg
// Types and constants shared by the gcd/lcm unit and its datapath
// ---------------------------------------------------------------------------
package glu_pkg;

  // fixed field widths of the request and result
  localparam int ValueWidth    = 32;
  localparam int DivisorWidth  = 33;
  localparam int MultipleWidth = 63;

  // request payload
  typedef struct packed {
    logic signed [ValueWidth-1:0] first_value;
    logic signed [ValueWidth-1:0] second_value;
  } glu_in_t;

  // result payload
  typedef struct packed {
    logic signed [DivisorWidth-1:0] divisor;
    logic [MultipleWidth-1:0]       multiple;
    logic                           multiple_exists;
  } glu_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_REDUCE,
    ST_DIV,
    ST_MUL
  } glu_state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ALIGN,
    OP_HALVE_A,
    OP_HALVE_B,
    OP_SWAP,
    OP_SUB,
    OP_SCALE,
    OP_DIV_STEP
  } glu_op_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic in_zero;
    logic a_even;
    logic b_even;
    logic a_eq_b;
    logic a_lt_b;
    logic cnt_zero;
  } glu_status_t;

endpackage

@@ rtl/glu_datapath.sv @@
// ---------------------------------------------------------------------------
// glu_datapath
// Operand registers, binary gcd and restoring divider on one shared
// subtractor, and the final multiplier
// ---------------------------------------------------------------------------
module glu_datapath
  import glu_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  glu_op_t     op,
  input  glu_in_t     in_data,
  output glu_status_t status,
  output glu_out_t    result
);

  localparam int W  = OPERAND_WIDTH;
  localparam int KW = $clog2(OPERAND_WIDTH);

  logic [W-1:0]  a_r, b_r, ma_r, mb_r, g_r, rem_r;
  logic [KW-1:0] k_r, cnt_r;
  logic          div_mode_r;

  logic [W-1:0]              a_in, b_in, a_mag, b_mag;
  logic signed [DivisorWidth-1:0] a_ext, b_ext, zero_sum;
  logic [W:0]                sub_x, sub_y;
  logic [W+1:0]              diff;
  logic                      borrow;
  logic [2*W-1:0]            prod;

  // operands at the configured width, their magnitudes and sign-extended sum
  assign a_in     = in_data.first_value[W-1:0];
  assign b_in     = in_data.second_value[W-1:0];
  assign a_mag    = a_in[W-1] ? (~a_in + W'(1)) : a_in;
  assign b_mag    = b_in[W-1] ? (~b_in + W'(1)) : b_in;
  assign a_ext    = {{(DivisorWidth-W){a_in[W-1]}}, a_in};
  assign b_ext    = {{(DivisorWidth-W){b_in[W-1]}}, b_in};
  assign zero_sum = a_ext + b_ext;

  // shared subtractor: a - b for gcd, partial remainder - g for division
  always_comb begin
    if (div_mode_r) begin
      sub_x = {rem_r, b_r[W-1]};
      sub_y = {1'b0, g_r};
    end else begin
      sub_x = {1'b0, a_r};
      sub_y = {1'b0, b_r};
    end
  end
  assign diff   = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow = diff[W+1];

  // lcm = |a| * (|b| / g), quotient left in b_r
  assign prod = {{W{1'b0}}, ma_r} * {{W{1'b0}}, b_r};

  // flags for the sequencer
  assign status.in_zero  = (a_in == '0) || (b_in == '0);
  assign status.a_even   = ~a_r[0];
  assign status.b_even   = ~b_r[0];
  assign status.a_eq_b   = (diff == '0);
  assign status.a_lt_b   = borrow;
  assign status.cnt_zero = (cnt_r == '0);

  // result: zero-operand case straight from the request, else gcd and lcm
  always_comb begin
    if (op == OP_LOAD) begin
      result.divisor         = zero_sum;
      result.multiple        = '0;
      result.multiple_exists = 1'b0;
    end else begin
      result.divisor         = {{(DivisorWidth-W){1'b0}}, g_r};
      result.multiple        = MultipleWidth'(prod);
      result.multiple_exists = 1'b1;
    end
  end

  // operand and iteration registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        a_r        <= a_mag;
        b_r        <= b_mag;
        ma_r       <= a_mag;
        mb_r       <= b_mag;
        k_r        <= '0;
        div_mode_r <= 1'b0;
      end
      OP_ALIGN: begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end
      OP_HALVE_A: begin
        a_r <= a_r >> 1;
      end
      OP_HALVE_B: begin
        b_r <= b_r >> 1;
      end
      OP_SWAP: begin
        a_r <= b_r;
        b_r <= a_r;
      end
      OP_SUB: begin
        a_r <= diff[W-1:0];
      end
      OP_SCALE: begin
        g_r        <= a_r << k_r;
        b_r        <= mb_r;
        rem_r      <= '0;
        cnt_r      <= KW'(W-1);
        div_mode_r <= 1'b1;
      end
      OP_DIV_STEP: begin
        rem_r <= borrow ? sub_x[W-1:0] : diff[W-1:0];
        b_r   <= {b_r[W-2:0], ~borrow};
        cnt_r <= cnt_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/gcd_lcm_unit.sv @@
// ---------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor and least common multiple of two signed operands
//
//   channel  ports                      transfer
//   request  start, busy, in_data       start high while busy low
//   result   out_valid, out_data        one-cycle strobe, no backpressure
//
// A request with a zero operand gives its result strobe in the next cycle.
// Otherwise: a load step, an align step per common factor of two, the binary
// gcd loop (a halving, swap or subtract per cycle on the shared subtractor), a
// scale step, a restoring divide into OPERAND_WIDTH quotient bits and a multiply
// step. busy is high until the strobe cycle; the receiver cannot stall; reset
// is synchronous and clears the sequencer and the strobe.
// ---------------------------------------------------------------------------
`include "gcd_lcm_unit_macros.svh"

module gcd_lcm_unit
  import glu_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  glu_in_t  in_data,
  output logic     out_valid,
  output glu_out_t out_data
);

  glu_state_t  state_r, state_nxt;
  glu_op_t     op;
  glu_status_t status;
  glu_out_t    result;
  glu_out_t    out_data_r;
  logic        out_valid_r;
  logic        load_out;
  logic        zero_accept;
  logic        zero_strobe;
  logic        full_strobe;

  glu_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .op     (op),
    .in_data(in_data),
    .status (status),
    .result (result)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && !status.in_zero) state_nxt = ST_ALIGN;
      end
      ST_ALIGN: begin
        if (!(status.a_even && status.b_even)) state_nxt = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (!status.a_even && !status.b_even && status.a_eq_b) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.cnt_zero) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath operation and result load
  always_comb begin
    op       = OP_HOLD;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op       = OP_LOAD;
          load_out = status.in_zero;
        end
      end
      ST_ALIGN: begin
        if (status.a_even && status.b_even) op = OP_ALIGN;
      end
      ST_REDUCE: begin
        priority if (status.a_even) op = OP_HALVE_A;
        else if (status.b_even)     op = OP_HALVE_B;
        else if (status.a_eq_b)     op = OP_SCALE;
        else if (status.a_lt_b)     op = OP_SWAP;
        else                        op = OP_SUB;
      end
      ST_DIV: begin
        op = OP_DIV_STEP;
      end
      ST_MUL: begin
        load_out = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // sequencer state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load_out;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // request and strobe terms for the checks
  assign zero_accept = start && !busy && status.in_zero;
  assign zero_strobe = out_valid_r && !out_data_r.multiple_exists;
  assign full_strobe = out_valid_r && out_data_r.multiple_exists;

  // checks
  `GLU_ASSERT_SAME(a_strobe_when_idle, out_valid_r, state_r == ST_IDLE)
  `GLU_ASSERT_NEXT(a_zero_case_next, zero_accept, zero_strobe)
  `GLU_ASSERT_NEXT(a_mul_gives_result, state_r == ST_MUL, full_strobe)
  `GLU_ASSERT_SAME(a_gcd_positive, full_strobe, out_data_r.divisor > 0)

endmodule

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for gcd_lcm_unit: a clocked driver issues requests from
// a queue of pending operand pairs, an independent predictor computes the
// expected gcd and lcm of each accepted request, and a clocked monitor checks
// every result strobe against the oldest prediction. Directed corner pairs
// come first, then random pairs under several sender idling patterns.
// ---------------------------------------------------------------------------
module testbench;
  import glu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          OperandWidth = 32;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned DrainCycles  = 250;
  localparam int unsigned RandomCount  = 1500;

  localparam logic [31:0] IntMin = 32'h8000_0000;
  localparam logic [31:0] IntMax = 32'h7FFF_FFFF;
  localparam logic [31:0] MinusOne = 32'hFFFF_FFFF;

  // one pending request with the idle probability of its phase
  typedef struct {
    glu_in_t     req;
    int unsigned idle_pct;
  } pending_req_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  glu_in_t  in_data = '0;
  logic     out_valid;
  glu_out_t out_data;

  pending_req_t pending_reqs[$];
  glu_out_t     expected_results[$];

  int unsigned total_reqs = 0;
  int unsigned issued_reqs = 0;
  int unsigned checked_results = 0;
  int unsigned no_multiple_results = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  gcd_lcm_unit #(
    .OPERAND_WIDTH(OperandWidth)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5ns clk = ~clk;

  // expected gcd / lcm of one request
  function automatic glu_out_t predict_gcd_lcm(glu_in_t req);
    logic [63:0] op_mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ext_a;
    logic [63:0] ext_b;
    logic [63:0] sum;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [63:0] prod;
    glu_out_t    res;
    op_mask = (64'd1 << OperandWidth) - 64'd1;
    a = {32'b0, req.first_value} & op_mask;
    b = {32'b0, req.second_value} & op_mask;
    res = '0;
    if (a == 64'd0 || b == 64'd0) begin
      // zero operand: signed sum, no multiple
      ext_a = a[OperandWidth-1] ? (a | ~op_mask) : a;
      ext_b = b[OperandWidth-1] ? (b | ~op_mask) : b;
      sum = ext_a + ext_b;
      res.divisor = sum[DivisorWidth-1:0];
      res.multiple = '0;
      res.multiple_exists = 1'b0;
    end else begin
      // magnitudes, exact for the most negative value
      if (a[OperandWidth-1]) a = (64'd1 << OperandWidth) - a;
      if (b[OperandWidth-1]) b = (64'd1 << OperandWidth) - b;
      x = a;
      y = b;
      while (y != 64'd0) begin
        r = x % y;
        x = y;
        y = r;
      end
      prod = a * b;
      res.divisor = x[DivisorWidth-1:0];
      res.multiple = MultipleWidth'(prod / x);
      res.multiple_exists = 1'b1;
    end
    return res;
  endfunction

  // one random operand, biased toward corners
  function automatic logic [31:0] draw_operand();
    logic [31:0] v;
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      v = '0;
    end else if (kind <= 3) begin
      case ($urandom_range(0, 3))
        0: v = IntMin;
        1: v = IntMax;
        2: v = 32'd1;
        default: v = MinusOne;
      endcase
    end else if (kind <= 9) begin
      v = $urandom;
    end else if (kind <= 14) begin
      v = 32'($urandom_range(1, 2000)) - 32'd1000;
    end else begin
      // random factor times a power of two
      v = (($urandom | 32'd1) >> $urandom_range(0, 31)) << $urandom_range(0, 31);
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  task automatic add_request(input logic [31:0] a, input logic [31:0] b,
                             input int unsigned idle_pct);
    pending_req_t item;
    item.req.first_value = a;
    item.req.second_value = b;
    item.idle_pct = idle_pct;
    pending_reqs.push_back(item);
    total_reqs++;
  endtask

  // driver: issue requests, record predictions on acceptance
  always @(posedge clk) begin : driver
    logic handed;
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      handed = start && !busy;
      if (handed) begin
        expected_results.push_back(predict_gcd_lcm(in_data));
        issued_reqs++;
      end
      if (!start || handed) begin
        if (pending_reqs.size() != 0 &&
            $urandom_range(0, 99) >= pending_reqs[0].idle_pct) begin
          in_data <= pending_reqs.pop_front().req;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result strobe with the oldest prediction
  always @(posedge clk) begin : monitor
    glu_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: divisor %0d multiple %0d exists %0b",
               out_data.divisor, out_data.multiple, out_data.multiple_exists);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        checked_results++;
        if (!want.multiple_exists) no_multiple_results++;
        if (out_data.divisor !== want.divisor) begin
          $error("divisor: expected %0d, actual %0d", want.divisor, out_data.divisor);
          mismatches++;
        end
        if (out_data.multiple !== want.multiple) begin
          $error("multiple: expected %0d, actual %0d", want.multiple, out_data.multiple);
          mismatches++;
        end
        if (out_data.multiple_exists !== want.multiple_exists) begin
          $error("multiple_exists: expected %0b, actual %0b",
                 want.multiple_exists, out_data.multiple_exists);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with neither a request nor a result accepted
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("timeout after %0d idle cycles", QuietLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] k;
    int unsigned idle_pct;
    int unsigned shape;

    // directed corners
    add_request(32'd0, 32'd0, 0);
    add_request(32'd0, 32'd5, 0);
    add_request(32'd5, 32'd0, 0);
    add_request(32'd0, MinusOne, 0);
    add_request(MinusOne, 32'd0, 0);
    add_request(32'd0, IntMin, 0);
    add_request(IntMin, 32'd0, 0);
    add_request(32'd0, IntMax, 0);
    add_request(IntMin, IntMin, 0);
    add_request(IntMax, IntMax, 0);
    add_request(IntMax, IntMin, 0);
    add_request(IntMin, MinusOne, 0);
    add_request(IntMax, IntMax - 32'd1, 0);
    add_request(MinusOne, MinusOne, 0);
    add_request(32'd1, 32'd1, 0);
    add_request(32'd1, IntMin, 0);
    add_request(32'd12, 32'd18, 0);
    add_request(-32'd12, 32'd18, 0);
    add_request(32'd12, -32'd18, 0);
    add_request(-32'd12, -32'd18, 0);
    add_request(32'h4000_0000, 32'h0010_0000, 0);
    add_request(32'd7, 32'd7, 0);
    add_request(32'hAAAA_AAAA, 32'h5555_5555, 0);

    // random pairs in three idling phases: none, heavy, light
    for (int unsigned i = 0; i < RandomCount; i++) begin
      if (i < RandomCount / 3) idle_pct = 0;
      else if (i < 2 * RandomCount / 3) idle_pct = 86;
      else idle_pct = 25;
      shape = $urandom_range(0, 19);
      if (shape < 8) begin
        a = draw_operand();
        b = draw_operand();
      end else if (shape < 15) begin
        // shared factor k, so the gcd is a multiple of k
        k = 32'($urandom_range(1, 4096));
        a = k * 32'($urandom_range(1, 65535));
        b = k * 32'($urandom_range(1, 65535));
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
      end else begin
        a = $urandom;
        b = $urandom;
      end
      add_request(a, b, idle_pct);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all requests and results, then let the block drain
    while (issued_reqs != total_reqs) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("issued %0d requests, checked %0d results (%0d with a zero operand)",
             issued_reqs, checked_results, no_multiple_results);
    $display("phases: directed corners, then random pairs with no, heavy and light idling");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ gcd_lcm_unit.f @@
+incdir+rtl
rtl/glu_pkg.sv
rtl/glu_datapath.sv
rtl/gcd_lcm_unit.sv
dv/testbench.sv
